[rtl/sme_pkg.sv]
package sme_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int HEAP_DEPTH  = 256;
  localparam int SP_W = $clog2(STACK_DEPTH);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int HA_W = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;
  localparam int HCNT_W = $clog2(HEAP_DEPTH + 1);

  typedef enum logic [3:0] {
    K_PUSH    = 4'd0,
    K_POP     = 4'd1,
    K_ADD     = 4'd2,
    K_SUB     = 4'd3,
    K_MUL     = 4'd4,
    K_DIV     = 4'd5,
    K_MOD     = 4'd6,
    K_STORE   = 4'd7,
    K_LOAD    = 4'd8,
    K_CHAROUT = 4'd9,
    K_INTOUT  = 4'd10,
    K_CHARIN  = 4'd11,
    K_INTIN   = 4'd12
  } kind_t;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_ADDR  = 3'd4;

  localparam logic [1:0] EM_NONE = 2'd0;
  localparam logic [1:0] EM_CHAR = 2'd1;
  localparam logic [1:0] EM_INT  = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_step;    // heap clearing write at clr address
    logic load_item;   // capture input item
    logic exec;        // evaluate operation on read operands
    logic div_start;
    logic finish;      // commit and build result
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic div_busy;
    logic need_div;
    logic need_heap;
  } stat_t;

endpackage

[rtl/sme_ram.sv]
module sme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/sme_div.sv]
module sme_div import sme_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);

  logic [5:0]  cnt_r, cnt_nxt;
  logic [31:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r, d_nxt;
  logic        qneg_r, qneg_nxt, rneg_r, rneg_nxt;
  logic [32:0] trial;

  assign busy = (cnt_r != 6'd0);
  assign trial = {rem_r[31:0], q_r[31]} - {1'b0, d_r};

  always_comb begin
    cnt_nxt = cnt_r;
    q_nxt = q_r;
    rem_nxt = rem_r;
    d_nxt = d_r;
    qneg_nxt = qneg_r;
    rneg_nxt = rneg_r;
    if (start) begin
      cnt_nxt = 6'd32;
      q_nxt = dividend[31] ? (32'd0 - dividend) : dividend;
      d_nxt = divisor[31] ? (32'd0 - divisor) : divisor;
      rem_nxt = '0;
      qneg_nxt = dividend[31] ^ divisor[31];
      rneg_nxt = dividend[31];
    end else if (busy) begin
      cnt_nxt = cnt_r - 6'd1;
      if (!trial[32]) begin
        rem_nxt = trial;
        q_nxt = {q_r[30:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[31:0], q_r[31]};
        q_nxt = {q_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    d_r <= d_nxt;
    qneg_r <= qneg_nxt;
    rneg_r <= rneg_nxt;
  end

  assign quotient  = qneg_r ? (32'd0 - q_r) : q_r;
  assign remainder = rneg_r ? (32'd0 - rem_r[31:0]) : rem_r[31:0];

endmodule

[rtl/sme_datapath.sv]
module sme_datapath import sme_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [3:0]       in_kind,
  input  logic [31:0]      in_operand,
  output logic [2:0]       res_status,
  output logic [1:0]       res_emit,
  output logic [31:0]      res_value,
  output logic [6:0]       res_depth
);

  logic [CNT_W-1:0]  cnt_r;
  logic [HCNT_W-1:0] clr_r;
  logic [3:0]        kind_r;
  logic [31:0]       opv_r;
  logic [31:0]       mul_r;
  logic [2:0]        st_r;
  logic              nd_r, nh_r;

  logic [SP_W-1:0]   ra_top, ra_sec, s_waddr;
  logic [31:0]       top, sec, s_wdata, h_wdata, h_rdata;
  logic              s_we, h_we;
  logic [HA_W-1:0]   h_waddr, h_raddr;
  logic              div_busy;
  logic [31:0]       quo, rem;
  logic [2:0]        st_c;
  logic              addr_ok_top, addr_ok_sec;
  logic [CNT_W-1:0]  cnt_new;
  logic [31:0]       res_w;
  logic [1:0]        em_c;
  logic [31:0]       ev_c;

  assign ra_top = SP_W'(cnt_r - CNT_W'(1));
  assign ra_sec = SP_W'(cnt_r - CNT_W'(2));

  sme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_top (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(ra_top), .rdata(top));
  sme_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_sec (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(ra_sec), .rdata(sec));
  sme_ram #(.WIDTH(32), .DEPTH(HEAP_DEPTH)) u_heap (
    .clk, .we(h_we), .waddr(h_waddr), .wdata(h_wdata), .raddr(h_raddr), .rdata(h_rdata));

  sme_div u_div (
    .clk, .rst_n, .start(cmd.div_start), .dividend(sec), .divisor(top),
    .busy(div_busy), .quotient(quo), .remainder(rem));

  assign addr_ok_top = (top[31] == 1'b0) && ({1'b0, top} < 33'(HEAP_DEPTH));
  assign addr_ok_sec = (sec[31] == 1'b0) && ({1'b0, sec} < 33'(HEAP_DEPTH));
  assign h_raddr = HA_W'(top);

  always_comb begin
    st_c = ST_OK;
    unique case (kind_r)
      K_PUSH: if (cnt_r >= CNT_W'(STACK_DEPTH)) st_c = ST_OVER;
      K_POP, K_CHAROUT, K_INTOUT: if (cnt_r < CNT_W'(1)) st_c = ST_UNDER;
      K_ADD, K_SUB, K_MUL: if (cnt_r < CNT_W'(2)) st_c = ST_UNDER;
      K_DIV, K_MOD: begin
        if (cnt_r < CNT_W'(2)) st_c = ST_UNDER;
        else if (top == 32'd0) st_c = ST_DIVZ;
      end
      K_STORE: begin
        if (cnt_r < CNT_W'(2)) st_c = ST_UNDER;
        else if (!addr_ok_sec) st_c = ST_ADDR;
      end
      K_LOAD, K_CHARIN, K_INTIN: begin
        if (cnt_r < CNT_W'(1)) st_c = ST_UNDER;
        else if (!addr_ok_top) st_c = ST_ADDR;
      end
      default: st_c = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      kind_r <= in_kind;
      opv_r <= in_operand;
    end
    if (cmd.exec) begin
      st_r <= st_c;
      mul_r <= sec * top;
      nd_r <= (st_c == ST_OK) && (kind_r == K_DIV || kind_r == K_MOD);
      nh_r <= (st_c == ST_OK) && (kind_r == K_LOAD);
    end
  end

  assign stat.need_div = nd_r;
  assign stat.need_heap = nh_r;
  assign stat.div_busy = div_busy;
  assign stat.clr_done = (clr_r == HCNT_W'(HEAP_DEPTH));

  always_comb begin
    cnt_new = cnt_r;
    s_we = 1'b0;
    s_waddr = ra_top;
    s_wdata = top;
    h_we = 1'b0;
    h_waddr = HA_W'(top);
    h_wdata = opv_r;
    em_c = EM_NONE;
    ev_c = '0;
    res_w = sec + top;
    unique case (kind_r)
      K_SUB: res_w = sec - top;
      K_MUL: res_w = mul_r;
      K_DIV: res_w = quo;
      K_MOD: res_w = rem;
      default: res_w = sec + top;
    endcase
    if (cmd.clr_step) begin
      h_we = 1'b1;
      h_waddr = HA_W'(clr_r);
      h_wdata = '0;
    end else if (cmd.finish && st_r == ST_OK) begin
      unique case (kind_r)
        K_PUSH: begin
          s_we = 1'b1;
          s_waddr = SP_W'(cnt_r);
          s_wdata = opv_r;
          cnt_new = cnt_r + CNT_W'(1);
        end
        K_POP: cnt_new = cnt_r - CNT_W'(1);
        K_ADD, K_SUB, K_MUL, K_DIV, K_MOD: begin
          s_we = 1'b1;
          s_waddr = ra_sec;
          s_wdata = res_w;
          cnt_new = cnt_r - CNT_W'(1);
        end
        K_STORE: begin
          h_we = 1'b1;
          h_waddr = HA_W'(sec);
          h_wdata = top;
          cnt_new = cnt_r - CNT_W'(2);
        end
        K_LOAD: begin
          s_we = 1'b1;
          s_wdata = h_rdata;
        end
        K_CHAROUT: begin
          cnt_new = cnt_r - CNT_W'(1);
          em_c = EM_CHAR;
          ev_c = {24'd0, top[7:0]};
        end
        K_INTOUT: begin
          cnt_new = cnt_r - CNT_W'(1);
          em_c = EM_INT;
          ev_c = top;
        end
        K_CHARIN: begin
          h_we = 1'b1;
          h_wdata = {{24{opv_r[7]}}, opv_r[7:0]};
          cnt_new = cnt_r - CNT_W'(1);
        end
        K_INTIN: begin
          h_we = 1'b1;
          cnt_new = cnt_r - CNT_W'(1);
        end
        default: cnt_new = cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      clr_r <= '0;
    end else begin
      if (cmd.finish) cnt_r <= cnt_new;
      if (cmd.clr_step) clr_r <= clr_r + HCNT_W'(1);
    end
    if (cmd.finish) begin
      res_status <= st_r;
      res_emit <= em_c;
      res_value <= ev_c;
      res_depth <= 7'(cnt_new);
    end
  end

`ifndef SYNTHESIS
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH)) else $error("stack count beyond depth");
  a_err_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && st_r != ST_OK |-> cnt_new == cnt_r) else $error("error changed stack");
  a_no_write_clr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !s_we) else $error("stack written while clearing");
`endif

endmodule

[rtl/sme_ctrl.sv]
module sme_ctrl import sme_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_fire,
  input  logic out_fire,
  input  stat_t stat,
  output cmd_t cmd,
  output logic in_ready,
  output logic out_valid
);

  typedef enum logic [7:0] {
    S_CLR  = 8'b0000_0001,
    S_IDLE = 8'b0000_0010,
    S_READ = 8'b0000_0100,
    S_EXEC = 8'b0000_1000,
    S_DIV  = 8'b0001_0000,
    S_DIVW = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_HEAP = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   ov_r, ov_nxt;

  assign in_ready = (state_r == S_IDLE) && (!ov_r || out_fire);
  assign out_valid = ov_r;

  always_comb begin
    cmd = '0;
    state_nxt = state_r;
    ov_nxt = ov_r && !out_fire;
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = !stat.clr_done;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_fire) begin
          cmd.load_item = 1'b1;
          state_nxt = S_READ;
        end
      end
      S_READ: state_nxt = S_EXEC;
      S_EXEC: begin
        cmd.exec = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (stat.need_div) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIVW;
        end else if (stat.need_heap) begin
          state_nxt = S_HEAP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIVW: if (!stat.div_busy) state_nxt = S_FIN;
      S_HEAP: state_nxt = S_FIN;
      S_FIN: begin
        cmd.finish = 1'b1;
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
    end
  end

`ifndef SYNTHESIS
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot(state_r)) else $error("state not one-hot");
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN |=> out_valid) else $error("result lost");
  a_no_in_clr: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_ready) else $error("item taken during clear");
`endif

endmodule

[rtl/stack_machine_executor.sv]
// Executes one stack-machine operation per item on a 64-word stack and a
// 256-word heap. After reset the heap is cleared word by word, and only then
// can the first item be taken. An item then passes from acceptance through
// read, execute, dispatch and finish states to its result, with a heap-read
// state added for a load and a wait on the one-bit-a-cycle divider for divide
// or modulo; a new item is taken only once the previous result has left the
// output register, at the earliest in the cycle in which that result is taken.
module stack_machine_executor import sme_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,  // kind[3:0], operand_value[35:4], zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata  // status, emit, emitted_value, stack_depth, pad
);

  cmd_t  cmd;
  stat_t stat;
  logic [2:0]  r_status;
  logic [1:0]  r_emit;
  logic [31:0] r_value;
  logic [6:0]  r_depth;
  logic in_fire, out_fire;

  assign in_fire = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;

  sme_ctrl u_ctrl (
    .clk, .rst_n, .in_fire, .out_fire, .stat, .cmd,
    .in_ready(in_tready), .out_valid(out_tvalid));

  sme_datapath u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_kind(in_tdata[3:0]), .in_operand(in_tdata[35:4]),
    .res_status(r_status), .res_emit(r_emit), .res_value(r_value),
    .res_depth(r_depth));

  assign out_tdata = {4'd0, r_depth, r_value, r_emit, r_status};

endmodule

[dv/testbench.sv]
module testbench import sme_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [3:0] K_SPARE_LO = 4'd13;
  localparam logic [3:0] K_SPARE_HI = 4'd15;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 60;

  typedef struct {
    logic [3:0]  kind;
    logic [31:0] value;
    bit          drain;
  } op_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [1:0]  emit;
    logic [31:0] value;
    logic [6:0]  depth;
  } op_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;  // kind, operand_value, zero pad
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata; // status, emit, emitted_value, stack_depth, zero pad

  stack_machine_executor DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  op_item_t   pending_ops[$];
  op_result_t expected_results[$];
  op_item_t   current_op;

  logic [31:0] model_stack[STACK_DEPTH] = '{default: '0};
  logic [31:0] model_heap[HEAP_DEPTH] = '{default: '0};
  int          model_depth = 0;

  int  ops_accepted;
  int  results_seen;
  int  mismatches = 0;
  int  unexpected = 0;
  int  error_results = 0;
  int  emit_results = 0;
  int  burst_left;
  int  gap_left;
  int  hold_left;
  bit  hold_done;
  int  rx_phase;
  int  rx_mode;
  int  cycles = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic bit heap_addr_ok(logic [31:0] a);
    return a < HEAP_DEPTH;
  endfunction

  function automatic op_result_t execute_op(logic [3:0] k, logic [31:0] v);
    op_result_t  res;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] r;
    res = '0;
    r = '0;
    case (k)
      K_PUSH: begin
        if (model_depth >= STACK_DEPTH) begin
          res.status = ST_OVER;
        end else begin
          model_stack[model_depth] = v;
          model_depth++;
        end
      end
      K_POP: begin
        if (model_depth < 1) res.status = ST_UNDER;
        else model_depth--;
      end
      K_ADD, K_SUB, K_MUL, K_DIV, K_MOD: begin
        if (model_depth < 2) begin
          res.status = ST_UNDER;
        end else begin
          b = model_stack[model_depth - 1];
          a = model_stack[model_depth - 2];
          if ((k == K_DIV || k == K_MOD) && b == 32'd0) begin
            res.status = ST_DIVZ;
          end else begin
            case (k)
              K_ADD: r = a + b;
              K_SUB: r = a - b;
              K_MUL: r = a * b;
              default: begin
                if (a == 32'h8000_0000 && b == 32'hFFFF_FFFF)
                  r = (k == K_DIV) ? a : 32'd0;
                else if (k == K_DIV)
                  r = $signed(a) / $signed(b);
                else
                  r = $signed(a) % $signed(b);
              end
            endcase
            model_depth--;
            model_stack[model_depth - 1] = r;
          end
        end
      end
      K_STORE: begin
        if (model_depth < 2) begin
          res.status = ST_UNDER;
        end else begin
          b = model_stack[model_depth - 1];
          a = model_stack[model_depth - 2];
          if (!heap_addr_ok(a)) begin
            res.status = ST_ADDR;
          end else begin
            model_heap[a] = b;
            model_depth -= 2;
          end
        end
      end
      K_LOAD: begin
        if (model_depth < 1) begin
          res.status = ST_UNDER;
        end else begin
          a = model_stack[model_depth - 1];
          if (!heap_addr_ok(a)) res.status = ST_ADDR;
          else model_stack[model_depth - 1] = model_heap[a];
        end
      end
      K_CHAROUT, K_INTOUT: begin
        if (model_depth < 1) begin
          res.status = ST_UNDER;
        end else begin
          a = model_stack[model_depth - 1];
          model_depth--;
          if (k == K_CHAROUT) begin
            res.emit = EM_CHAR;
            res.value = {24'd0, a[7:0]};
          end else begin
            res.emit = EM_INT;
            res.value = a;
          end
        end
      end
      K_CHARIN, K_INTIN: begin
        if (model_depth < 1) begin
          res.status = ST_UNDER;
        end else begin
          a = model_stack[model_depth - 1];
          if (!heap_addr_ok(a)) begin
            res.status = ST_ADDR;
          end else begin
            model_heap[a] = (k == K_CHARIN) ? {{24{v[7]}}, v[7:0]} : v;
            model_depth--;
          end
        end
      end
      default: ;
    endcase
    res.depth = model_depth[6:0];
    return res;
  endfunction

  task automatic add_op(logic [3:0] k, logic [31:0] v = 32'd0, bit drain = 1'b0);
    op_item_t it;
    it.kind = k;
    it.value = v;
    it.drain = drain;
    pending_ops.push_back(it);
  endtask

  function automatic logic [31:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, HEAP_DEPTH - 1);
    if (r < 92) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_word();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 32'd0;
    if (r == 1) return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
    if (r == 2) return 32'hFFFF_FFFF;
    if (r < 5) return $urandom_range(0, 20) - 10;
    return $urandom;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
      ops_accepted <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(execute_op(current_op.kind, current_op.value));
        ops_accepted <= ops_accepted + 1;
      end
      if (!(in_tvalid && !in_tready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (burst_left == 0) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
          in_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0 && !(pending_ops[0].drain &&
                     (ops_accepted + (in_tvalid && in_tready) != results_seen))) begin
          current_op = pending_ops.pop_front();
          in_tdata <= {4'd0, current_op.value, current_op.kind};
          in_tvalid <= 1'b1;
          burst_left <= burst_left - 1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: a stall pattern that changes mode, plus one long hold-off.
  always @(posedge clk) begin
    op_result_t got;
    op_result_t want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      results_seen <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
      rx_phase <= 0;
      rx_mode <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got.status = out_tdata[2:0];
        got.emit = out_tdata[4:3];
        got.value = out_tdata[36:5];
        got.depth = out_tdata[43:37];
        results_seen <= results_seen + 1;
        if (got.status != ST_OK) error_results++;
        if (got.emit != EM_NONE) emit_results++;
        if (expected_results.size() == 0) begin
          unexpected++;
          if (unexpected + mismatches <= 10)
            $display("unexpected result item %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches + unexpected <= 10)
              $display("mismatch on result %0d: status %0d/%0d emit %0d/%0d value %h/%h depth %0d/%0d (expected/actual)",
                       results_seen, want.status, got.status, want.emit, got.emit,
                       want.value, got.value, want.depth, got.depth);
          end
        end
      end
      rx_phase <= rx_phase + 1;
      if (rx_phase % 80 == 0) rx_mode <= $urandom_range(0, 2);
      if (!hold_done && results_seen >= 300) begin
        hold_done <= 1'b1;
        hold_left <= 400;
        out_tready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_tready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= $urandom_range(0, 1);
          default: out_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int n;
    int r;
    int runs;
    logic [3:0] k;
    rst_n = 1'b0;

    add_op(K_POP);
    add_op(K_STORE);
    add_op(K_PUSH, 32'h8000_0000);
    add_op(K_PUSH, 32'hFFFF_FFFF);
    add_op(K_DIV);
    add_op(K_PUSH, 32'hFFFF_FFFF);
    add_op(K_MOD);
    add_op(K_DIV);
    add_op(K_PUSH, 32'hFFFF_FFF9);
    add_op(K_PUSH, 32'd2);
    add_op(K_MOD);
    add_op(K_PUSH, 32'h7FFF_FFFF);
    add_op(K_MUL);
    add_op(K_SUB);
    add_op(K_ADD);
    add_op(K_INTOUT);
    add_op(K_PUSH, 32'd300);
    add_op(K_LOAD);
    add_op(K_PUSH, 32'd255);
    add_op(K_PUSH, 32'h1234_5678);
    add_op(K_STORE);
    add_op(K_PUSH, 32'd3);
    add_op(K_CHARIN, 32'h0000_FF80);
    add_op(K_PUSH, 32'd3);
    add_op(K_LOAD);
    add_op(K_CHAROUT);
    add_op(K_PUSH, 32'd7);
    add_op(K_INTIN, 32'h7FFF_FFFF);
    add_op(K_LOAD);
    add_op(K_CHAROUT);
    add_op(K_SPARE_LO, 32'hFFFF_FFFF);
    add_op(K_SPARE_HI);

    n = 0;
    runs = 0;
    while (n < 1100) begin
      r = $urandom_range(0, 99);
      if (r < 20) begin
        add_op(K_PUSH, pick_word());
        add_op(K_PUSH, pick_word());
        k = 4'($urandom_range(K_ADD, K_MOD));
        add_op(k);
        add_op($urandom_range(0, 1) ? K_INTOUT : K_CHAROUT);
        n += 4;
      end else if (r < 35) begin
        add_op(K_PUSH, pick_addr());
        add_op(K_PUSH, pick_word());
        add_op(K_STORE);
        n += 3;
      end else if (r < 50) begin
        add_op(K_PUSH, pick_addr());
        add_op(K_LOAD);
        add_op($urandom_range(0, 1) ? K_INTOUT : K_POP);
        n += 3;
      end else if (r < 62) begin
        add_op(K_PUSH, pick_addr());
        add_op($urandom_range(0, 1) ? K_CHARIN : K_INTIN, $urandom);
        n += 2;
      end else if (r < 74) begin
        add_op(K_PUSH, pick_word());
        n += 1;
      end else if (r < 84) begin
        add_op(4'($urandom_range(0, 15)), $urandom);
        n += 1;
      end else if (r < 86 && runs < 2) begin
        runs++;
        for (int i = 0; i < STACK_DEPTH + 3; i++) add_op(K_PUSH, $urandom);
        for (int i = 0; i < STACK_DEPTH + 3; i++) add_op(K_INTOUT);
        n += 2 * (STACK_DEPTH + 3);
      end else begin
        add_op($urandom_range(0, 2) == 0 ? K_POP : K_INTOUT);
        n += 1;
      end
      if (n % 250 < 4) pending_ops[$].drain = 1'b1;
    end

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    wait (pending_ops.size() == 0 && !in_tvalid);
    wait (results_seen == ops_accepted);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d operation items, %0d results, %0d with error status, %0d emitting",
             ops_accepted, results_seen, error_results, emit_results);
    if (mismatches == 0 && unexpected == 0 && expected_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d unexpected, %0d missing",
               mismatches, unexpected, expected_results.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
